FILE: rtl/core/upe_pkg.sv
package upe_pkg;

	localparam int CpW      = 21;
	localparam int CharW    = 7;
	localparam int ByteW    = 8;
	localparam int MaxBytes = 4;
	localparam int MaxChars = 12;
	localparam int CntW     = 4;
	localparam int NbW      = 3;

	localparam logic [CpW-1:0]   MaxCodePoint = 21'h10FFFF;
	localparam logic [CharW-1:0] PctChar      = 7'h25;
	localparam logic [CharW-1:0] ZeroChar     = 7'h30;
	localparam logic [CharW-1:0] AlphaBase    = 7'h37;

	typedef logic [CharW-1:0] char_t;
	typedef logic [ByteW-1:0] byte_t;

	typedef struct packed {
		char_t [MaxChars-1:0] chars;
		logic  [CntW-1:0]     count;
	} burst_t;

	function automatic logic is_reserved(input logic [CharW-1:0] c);
		case (c) inside
			7'h09, 7'h0A, 7'h20, 7'h21, 7'h23, 7'h24, 7'h25, 7'h26,
			7'h27, 7'h28, 7'h29, 7'h2A, 7'h2B, 7'h2C, 7'h2F, 7'h3A,
			7'h3B, 7'h3D, 7'h3F, 7'h40, 7'h5B, 7'h5D: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic char_t hex_char(input logic [3:0] d);
		if (d < 4'd10)
			return ZeroChar + {3'b000, d};
		else
			return AlphaBase + {3'b000, d};
	endfunction

endpackage

FILE: rtl/core/upe_serializer.sv
module upe_serializer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            burst_valid,
	input  upe_pkg::burst_t burst,
	output logic            take,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [6:0]      out_char,
	output logic            last_char
);

	upe_pkg::char_t [upe_pkg::MaxChars-1:0] buf_q;
	logic [upe_pkg::CntW-1:0]               left_q;
	logic                                   busy_q;
	logic                                   out_acc;

	assign out_acc   = busy_q && !out_stall;
	assign last_char = (left_q == upe_pkg::CntW'(1));
	assign take      = !busy_q || (out_acc && last_char);
	assign out_valid = busy_q;
	assign out_char  = buf_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			left_q <= '0;
		end else if (take) begin
			busy_q <= burst_valid;
			left_q <= burst_valid ? burst.count : '0;
		end else if (out_acc) begin
			left_q <= left_q - upe_pkg::CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take && burst_valid) begin
			buf_q <= burst.chars;
		end else if (out_acc) begin
			for (int i = 0; i < upe_pkg::MaxChars - 1; i++)
				buf_q[i] <= buf_q[i+1];
		end
	end

	// burst length stays within bounds while characters are pending
	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (left_q != '0 && left_q <= upe_pkg::CntW'(upe_pkg::MaxChars)))
		else $error("burst count out of range");

	// a taken character that is not the last keeps the burst going
	a_left_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && !last_char) |=> (busy_q && left_q == $past(left_q) - 4'd1))
		else $error("burst count did not step");

	// an empty serialiser always takes the next burst
	a_idle_take: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> take)
		else $error("idle serialiser refused a burst");

	// a stalled burst keeps its length
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && out_stall) |=> (busy_q && $stable(left_q)))
		else $error("burst count moved under stall");

endmodule

FILE: rtl/core/uri_percent_encoder.sv
// URI percent encoder. One Unicode code point is taken per beat on the input
// channel and leaves as a burst of ASCII characters, one per output beat, with
// last_char high on the final character. Unreserved ASCII passes as one
// character, reserved ASCII becomes three (%XX), and code points of 128 and
// above are UTF-8 encoded and percent-escaped into 6, 9 or 12 characters;
// values above 10FFFF produce no output. The input is taken every cycle unless
// in_stall is high, through three register stages (input register, range check
// and UTF-8 byte split, hex expansion) into an output shift register; the output
// serialiser is the limit, as each code point holds it until all of its
// characters have left.
module uri_percent_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [20:0] code_point,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  out_char,
	output logic        last_char
);

	logic [upe_pkg::CpW-1:0] cp_s1;
	logic                    valid_s1;

	upe_pkg::byte_t [upe_pkg::MaxBytes-1:0] bytes_s2;
	logic [upe_pkg::NbW-1:0]                nbyte_s2;
	logic                                   plain_s2;
	logic                                   valid_s2;

	upe_pkg::burst_t burst_s3;
	logic            valid_s3;

	logic en1, en2, en3, take;

	upe_pkg::byte_t [upe_pkg::MaxBytes-1:0] bytes_d;
	logic [upe_pkg::NbW-1:0]                nbyte_d;
	logic                                   plain_d;
	logic                                   inrange_d;
	upe_pkg::burst_t                        burst_d;

	assign en3      = !valid_s3 || take;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_stall = !en1;

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid)
			cp_s1 <= code_point;
	end

	// stage 2: classify and split into utf-8 bytes
	always_comb begin
		bytes_d   = '0;
		nbyte_d   = upe_pkg::NbW'(1);
		plain_d   = 1'b0;
		inrange_d = 1'b1;
		if (cp_s1[20:7] == '0) begin
			bytes_d[0] = {1'b0, cp_s1[6:0]};
			plain_d    = !upe_pkg::is_reserved(cp_s1[6:0]);
		end else if (cp_s1[20:11] == '0) begin
			bytes_d[0] = {3'b110, cp_s1[10:6]};
			bytes_d[1] = {2'b10, cp_s1[5:0]};
			nbyte_d    = upe_pkg::NbW'(2);
		end else if (cp_s1[20:16] == '0) begin
			bytes_d[0] = {4'b1110, cp_s1[15:12]};
			bytes_d[1] = {2'b10, cp_s1[11:6]};
			bytes_d[2] = {2'b10, cp_s1[5:0]};
			nbyte_d    = upe_pkg::NbW'(3);
		end else begin
			bytes_d[0] = {5'b11110, cp_s1[20:18]};
			bytes_d[1] = {2'b10, cp_s1[17:12]};
			bytes_d[2] = {2'b10, cp_s1[11:6]};
			bytes_d[3] = {2'b10, cp_s1[5:0]};
			nbyte_d    = upe_pkg::NbW'(4);
			inrange_d  = (cp_s1 <= upe_pkg::MaxCodePoint);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1 && inrange_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			bytes_s2 <= bytes_d;
			nbyte_s2 <= nbyte_d;
			plain_s2 <= plain_d;
		end
	end

	// stage 3: expand bytes into escaped characters
	always_comb begin
		burst_d = '0;
		for (int i = 0; i < upe_pkg::MaxBytes; i++) begin
			burst_d.chars[3*i]   = upe_pkg::PctChar;
			burst_d.chars[3*i+1] = upe_pkg::hex_char(bytes_s2[i][7:4]);
			burst_d.chars[3*i+2] = upe_pkg::hex_char(bytes_s2[i][3:0]);
		end
		if (plain_s2) begin
			burst_d.chars[0] = bytes_s2[0][6:0];
			burst_d.count    = upe_pkg::CntW'(1);
		end else begin
			case (nbyte_s2)
				3'd1:    burst_d.count = upe_pkg::CntW'(3);
				3'd2:    burst_d.count = upe_pkg::CntW'(6);
				3'd3:    burst_d.count = upe_pkg::CntW'(9);
				default: burst_d.count = upe_pkg::CntW'(12);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && valid_s2)
			burst_s3 <= burst_d;
	end

	upe_serializer u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.burst_valid (valid_s3),
		.burst       (burst_s3),
		.take        (take),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.last_char   (last_char)
	);

	// stage 3 holding a beat that cannot move keeps it
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !take) |=> (valid_s3 && $stable(burst_s3)))
		else $error("stage 3 beat lost under stall");

	// input is stalled only when every stage is full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && out_valid))
		else $error("input stalled with room in the pipeline");

	// an out-of-range code point never reaches stage 2
	a_drop_range: assert property (@(posedge clk) disable iff (!arst_n)
		(en2 && valid_s1 && cp_s1 > upe_pkg::MaxCodePoint) |=> !valid_s2)
		else $error("out-of-range code point passed");

endmodule
